[hw/rtl/voxel_gradient_normalizer_defines.svh]
// ----------------------------------------------------------------------------
// voxel_gradient_normalizer_defines.svh
// Assertion macros shared by the gradient normalizer RTL.
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRADIENT_NORMALIZER_DEFINES_SVH
`define VOXEL_GRADIENT_NORMALIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst
`define VGN_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst
`define VGN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/vgn_pkg.sv]
// ----------------------------------------------------------------------------
// vgn_pkg
// Shared constants and types of the voxel gradient normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package vgn_pkg;

  // Reciprocal spacing registers, unsigned Q8.8
  localparam int SPACING_WIDTH = 16;
  localparam logic [SPACING_WIDTH-1:0] SPACING_RESET = 16'd256;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_RECIP_X = 2'd0,
    REG_RECIP_Y = 2'd1,
    REG_RECIP_Z = 2'd2
  } cfg_reg_e;

  // Result fields
  localparam int MAG_WIDTH = 33;
  localparam int DIR_WIDTH = 16;
  // Quotient bits of g * 2^15 / (2 * len), rounds half away from zero
  localparam int QUOT_WIDTH = 15;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } vgn_fifo_status_t;

endpackage

`default_nettype wire

[hw/rtl/voxel_gradient_normalizer.sv]
// ----------------------------------------------------------------------------
// voxel_gradient_normalizer
// Gradient length and unit direction of one voxel from its six neighbors.
// ----------------------------------------------------------------------------
// Takes one neighborhood per clock and returns one result per clock, in
// order, while m_tready does not stall the output. The front part (three
// stages: capture, scale, square) feeds a two-entry queue; the back part
// sums the squares, resolves the square root one bit per stage
// (SAMPLE_WIDTH + 17 stages) and divides all three components by the
// length one quotient bit per stage (15 stages). The input side keeps
// taking transfers while the output is stalled until the queue fills and
// the last front stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_gradient_normalizer
  import vgn_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Configuration writes
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [SPACING_WIDTH-1:0]   cfg_wdata,
  // Input stream
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // From bit 0: center_sample, x_next_sample, x_prev_sample, y_next_sample,
  // y_prev_sample, z_next_sample, z_prev_sample, edge_flags, zero fill
  input  wire logic [((7*SAMPLE_WIDTH+6+7)/8)*8-1:0] s_tdata,
  // Output stream
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // From bit 0: magnitude, dir_x, dir_y, dir_z, zero_gradient, zero fill
  output logic [((MAG_WIDTH+3*DIR_WIDTH+1+7)/8)*8-1:0] m_tdata
);

  `include "voxel_gradient_normalizer_defines.svh"

  localparam int EW = 9*(SAMPLE_WIDTH+SPACING_WIDTH) + 3;

  logic [SPACING_WIDTH-1:0] recip_x, recip_y, recip_z;
  logic                     push, pop;
  logic [EW-1:0]            push_data, pop_data;
  vgn_fifo_status_t         fifo_status;

  // Reciprocal spacing registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      recip_x <= SPACING_RESET;
      recip_y <= SPACING_RESET;
      recip_z <= SPACING_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_e'(cfg_index))
        REG_RECIP_X: recip_x <= cfg_wdata;
        REG_RECIP_Y: recip_y <= cfg_wdata;
        REG_RECIP_Z: recip_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vgn_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .recip_x     (recip_x),
    .recip_y     (recip_y),
    .recip_z     (recip_z),
    .fifo_status (fifo_status),
    .push        (push),
    .push_data   (push_data)
  );

  vgn_fifo #(.WIDTH(EW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (fifo_status)
  );

  vgn_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_status (fifo_status),
    .pop_data    (pop_data),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  // Queue never overflows or underflows; a flat field has no direction
  `VGN_ASSERT_NOW(a_no_overflow, push, !fifo_status.full, "queue overflow")
  `VGN_ASSERT_NOW(a_no_underflow, pop, !fifo_status.empty, "queue underflow")
  `VGN_ASSERT_NOW(a_zero_dir, m_tvalid && m_tdata[MAG_WIDTH+3*DIR_WIDTH],
                  m_tdata[MAG_WIDTH +: 3*DIR_WIDTH] == '0, "direction on zero gradient")

endmodule

`default_nettype wire

[hw/rtl/vgn_front.sv]
// ----------------------------------------------------------------------------
// vgn_front
// Accepts neighborhoods, applies edge replication, scales the central
// differences and squares them; pushes each item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vgn_front
  import vgn_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [((7*SAMPLE_WIDTH+6+7)/8)*8-1:0] s_tdata,
  input  wire logic [SPACING_WIDTH-1:0] recip_x,
  input  wire logic [SPACING_WIDTH-1:0] recip_y,
  input  wire logic [SPACING_WIDTH-1:0] recip_z,
  input  wire vgn_fifo_status_t         fifo_status,
  output logic                          push,
  output logic [9*(SAMPLE_WIDTH+SPACING_WIDTH)+2:0] push_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int GW = SW + SPACING_WIDTH;

  logic                 en;
  logic                 v1, v2, v3;
  logic signed [SW-1:0] smp [0:6];
  logic [5:0]           flags;
  logic [SPACING_WIDTH-1:0] recip [0:2];
  logic [SW-1:0]        absd [0:2];
  logic [2:0]           negd;
  logic [GW-1:0]        g2 [0:2];
  logic [2:0]           neg2;
  logic [GW-1:0]        g3 [0:2];
  logic [2:0]           neg3;
  logic [2*GW-1:0]      sq3 [0:2];

  assign recip[0] = recip_x;
  assign recip[1] = recip_y;
  assign recip[2] = recip_z;

  // Advance unless the last stage holds an item the queue cannot take
  assign en       = !(v3 && fifo_status.full);
  assign s_tready = en;
  assign push     = v3 && !fifo_status.full;

  // Stage 1: capture the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 7; i++) begin
        smp[i] <= s_tdata[i*SW +: SW];
      end
      flags <= s_tdata[7*SW +: 6];
    end
  end

  // Replicate the center at volume edges, take |next - prev|
  always_comb begin
    logic signed [SW-1:0] n, p;
    logic signed [SW:0]   d, ad;
    for (int a = 0; a < 3; a++) begin
      n       = flags[2*a]   ? smp[0] : smp[1+2*a];
      p       = flags[2*a+1] ? smp[0] : smp[2+2*a];
      d       = (SW+1)'(n) - (SW+1)'(p);
      negd[a] = d[SW];
      ad      = d[SW] ? -d : d;
      absd[a] = ad[SW-1:0];
    end
  end

  // Stage 2: scale by reciprocal spacing
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        g2[a] <= GW'(absd[a]) * GW'(recip[a]);
      end
      neg2 <= negd;
    end
  end

  // Stage 3: square each component
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sq3[a] <= (2*GW)'(g2[a]) * (2*GW)'(g2[a]);
        g3[a]  <= g2[a];
      end
      neg3 <= neg2;
    end
  end

  assign push_data = {sq3[2], sq3[1], sq3[0], neg3, g3[2], g3[1], g3[0]};

endmodule

`default_nettype wire

[hw/rtl/vgn_fifo.sv]
// ----------------------------------------------------------------------------
// vgn_fifo
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module vgn_fifo
  import vgn_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output vgn_fifo_status_t      status
);

  logic [WIDTH-1:0] mem [0:1];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_data     = mem[rd_ptr];

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Hold the entries
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

[hw/rtl/vgn_back.sv]
// ----------------------------------------------------------------------------
// vgn_back
// Sums the squares, takes the integer square root one bit per stage and
// divides each component by the length one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vgn_back
  import vgn_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vgn_fifo_status_t    fifo_status,
  input  wire logic [9*(SAMPLE_WIDTH+SPACING_WIDTH)+2:0] pop_data,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [((MAG_WIDTH+3*DIR_WIDTH+1+7)/8)*8-1:0] m_tdata
);

  localparam int GW    = SAMPLE_WIDTH + SPACING_WIDTH;
  localparam int SUMW  = 2*GW + 2;
  localparam int RW    = GW + 1;
  localparam int DW    = RW + QUOT_WIDTH + 1;
  localparam int QW    = QUOT_WIDTH;
  localparam int XW    = (RW > MAG_WIDTH) ? RW : MAG_WIDTH;
  localparam int OTD_W = ((MAG_WIDTH+3*DIR_WIDTH+1+7)/8)*8;

  logic en;

  // Square-root pipeline
  logic            sv    [0:RW];
  logic [SUMW-1:0] rem   [0:RW];
  logic [RW-1:0]   root  [0:RW];
  logic [GW-1:0]   sg    [0:RW][0:2];
  logic [2:0]      sn    [0:RW];
  logic [SUMW-1:0] trial [0:RW-1];
  logic [RW-1:0]   rset  [0:RW-1];
  logic            take  [0:RW-1];

  // Divider pipeline
  logic            dv    [0:QW];
  logic [DW-1:0]   drem  [0:QW][0:2];
  logic [DW-1:0]   dden  [0:QW];
  logic [QW-1:0]   dq    [0:QW][0:2];
  logic [RW-1:0]   dlen  [0:QW];
  logic [2:0]      dneg  [0:QW];
  logic [DW-1:0]   dsub  [0:QW-1];
  logic            dtake [0:QW-1][0:2];

  logic [XW-1:0]        len_ext;
  logic [MAG_WIDTH-1:0] mag;
  logic                 zero;
  logic [DIR_WIDTH-1:0] dir [0:2];

  // Advance when the output register is free or being taken
  assign en  = !m_tvalid || m_tready;
  assign pop = en && !fifo_status.empty;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= RW; k++) sv[k] <= 1'b0;
      for (int j = 0; j <= QW; j++) dv[j] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      sv[0] <= pop;
      for (int k = 0; k < RW; k++) sv[k+1] <= sv[k];
      dv[0] <= sv[RW];
      for (int j = 0; j < QW; j++) dv[j+1] <= dv[j];
      m_tvalid <= dv[QW];
    end
  end

  // Trial subtrahend per root bit: root * 2^(b+1) + 2^(2b)
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      trial[k] = (SUMW'(root[k]) << (RW-k)) | (SUMW'(1) << (2*(RW-1-k)));
      rset[k]  = root[k] | (RW'(1) << (RW-1-k));
      take[k]  = rem[k] >= trial[k];
    end
  end

  // Sum of squares, then one root bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= SUMW'(pop_data[3*GW+3 +: 2*GW])
               + SUMW'(pop_data[3*GW+3+2*GW +: 2*GW])
               + SUMW'(pop_data[3*GW+3+4*GW +: 2*GW]);
      root[0] <= '0;
      for (int a = 0; a < 3; a++) sg[0][a] <= pop_data[a*GW +: GW];
      sn[0]   <= pop_data[3*GW +: 3];
      for (int k = 0; k < RW; k++) begin
        rem[k+1]  <= take[k] ? rem[k] - trial[k] : rem[k];
        root[k+1] <= take[k] ? rset[k] : root[k];
        for (int a = 0; a < 3; a++) sg[k+1][a] <= sg[k][a];
        sn[k+1]   <= sn[k];
      end
    end
  end

  // Shifted divisor per quotient bit
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      dsub[j] = dden[j] << (QW-1-j);
      for (int a = 0; a < 3; a++) dtake[j][a] = drem[j][a] >= dsub[j];
    end
  end

  // Divide (g * 2^15 + len) by 2 * len, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        drem[0][a] <= (DW'(sg[RW][a]) << QW) + DW'(root[RW]);
        dq[0][a]   <= '0;
      end
      dden[0] <= DW'(root[RW]) << 1;
      dlen[0] <= root[RW];
      dneg[0] <= sn[RW];
      for (int j = 0; j < QW; j++) begin
        for (int a = 0; a < 3; a++) begin
          drem[j+1][a] <= dtake[j][a] ? drem[j][a] - dsub[j] : drem[j][a];
          dq[j+1][a]   <= dq[j][a] | (dtake[j][a] ? (QW'(1) << (QW-1-j)) : QW'(0));
        end
        dden[j+1] <= dden[j];
        dlen[j+1] <= dlen[j];
        dneg[j+1] <= dneg[j];
      end
    end
  end

  // Saturate the length, apply signs, force zero direction on a flat field
  always_comb begin
    len_ext = XW'(dlen[QW]);
    zero    = (dlen[QW] == '0);
    mag     = ((len_ext >> MAG_WIDTH) != '0) ? '1 : len_ext[MAG_WIDTH-1:0];
    for (int a = 0; a < 3; a++) begin
      if (zero) begin
        dir[a] = '0;
      end else if (dneg[QW][a]) begin
        dir[a] = -DIR_WIDTH'(dq[QW][a]);
      end else begin
        dir[a] = DIR_WIDTH'(dq[QW][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OTD_W'({zero, dir[2], dir[1], dir[0], mag});
    end
  end

endmodule

`default_nettype wire
